### src/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants for the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int INDEX_W  = 16;
  localparam int LEN_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } ile_op_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [CNT_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } ile_cmd_t;

endpackage

### src/ile_cell.sv
// ----------------------------------------------------------------------------
// ile_cell
// One list slot. Insert: left neighbor above the position, new value at it.
// Delete: right neighbor from it up. Drives its word onto the read bus when addressed.
// ----------------------------------------------------------------------------
module ile_cell (
  input  logic                          clk,
  input  ile_pkg::ile_cmd_t             cmd_i,
  input  logic [ile_pkg::IDX_W-1:0]     cell_id_i,
  input  logic [ile_pkg::DATA_W-1:0]    left_i,
  input  logic [ile_pkg::DATA_W-1:0]    right_i,
  output logic [ile_pkg::DATA_W-1:0]    data_o,
  output logic [ile_pkg::DATA_W-1:0]    rd_o
);

  logic [ile_pkg::DATA_W-1:0] data_r;
  logic [ile_pkg::CNT_W-1:0]  id_ext;

  assign id_ext = ile_pkg::CNT_W'(cell_id_i);

  always_ff @(posedge clk) begin
    if (cmd_i.ins) begin
      if (id_ext > cmd_i.pos) begin
        data_r <= left_i;
      end else if (id_ext == cmd_i.pos) begin
        data_r <= cmd_i.value;
      end
    end else if (cmd_i.del && (id_ext >= cmd_i.pos)) begin
      data_r <= right_i;
    end
  end

  assign data_o = data_r;
  assign rd_o   = (id_ext == cmd_i.pos) ? data_r : '0;

endmodule

### src/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed words kept in a chain of shift cells.
// Result registered when the request is accepted. Throughput: 1 request per
// cycle unless the output stalls; cells shift in parallel in that cycle.
// Reset: length cleared to zero, output channel empty; cell contents are
// left as is and never read before written.
// ----------------------------------------------------------------------------
module indexed_list_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ile_pkg::OP_W-1:0]      in_op,
  input  logic signed [ile_pkg::INDEX_W-1:0] in_index,
  input  logic signed [ile_pkg::DATA_W-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ile_pkg::DATA_W-1:0]  out_read_value,
  output logic                          out_ok,
  output logic [ile_pkg::LEN_W-1:0]     out_length
);

  logic                         accept;
  logic [ile_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                         out_valid_r;
  logic [ile_pkg::DATA_W-1:0]   out_read_value_r, read_value_nxt;
  logic                         out_ok_r, ok_nxt;
  logic [ile_pkg::LEN_W-1:0]    out_length_r;
  ile_pkg::ile_cmd_t            cmd;
  logic                         room, idx_neg, idx_hit, idx_le;
  logic [ile_pkg::INDEX_W-1:0]  cnt_ext;
  logic [ile_pkg::DATA_W-1:0]   cell_data [ile_pkg::CAPACITY];
  logic [ile_pkg::DATA_W-1:0]   cell_rd   [ile_pkg::CAPACITY];
  logic [ile_pkg::DATA_W-1:0]   rd_bus;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  assign room    = (count_r < ile_pkg::CNT_W'(ile_pkg::CAPACITY));
  assign idx_neg = in_index[ile_pkg::INDEX_W-1];
  assign cnt_ext = ile_pkg::INDEX_W'(count_r);
  assign idx_hit = !idx_neg && (in_index < cnt_ext);
  assign idx_le  = !idx_neg && (in_index <= cnt_ext);

  // Request decode
  always_comb begin
    cmd.ins        = 1'b0;
    cmd.del        = 1'b0;
    cmd.pos        = in_index[ile_pkg::CNT_W-1:0];
    cmd.value      = in_value;
    ok_nxt         = 1'b0;
    read_value_nxt = '0;
    count_nxt      = count_r;
    unique case (in_op)
      ile_pkg::OP_GET: begin
        ok_nxt         = idx_hit;
        read_value_nxt = idx_hit ? rd_bus : '1;
      end
      ile_pkg::OP_HEAD: begin
        cmd.pos = '0;
        ok_nxt  = room;
      end
      ile_pkg::OP_TAIL: begin
        cmd.pos = count_r;
        ok_nxt  = room;
      end
      ile_pkg::OP_INSERT: begin
        if (idx_neg) begin
          cmd.pos = '0;
        end
        ok_nxt = room && (idx_neg || idx_le);
      end
      ile_pkg::OP_DELETE: begin
        ok_nxt = idx_hit;
      end
      default: begin
      end
    endcase
    if (accept && ok_nxt) begin
      if (in_op == ile_pkg::OP_HEAD || in_op == ile_pkg::OP_TAIL ||
          in_op == ile_pkg::OP_INSERT) begin
        cmd.ins   = 1'b1;
        count_nxt = ile_pkg::CNT_W'(count_r + 1'b1);
      end else if (in_op == ile_pkg::OP_DELETE) begin
        cmd.del   = 1'b1;
        count_nxt = ile_pkg::CNT_W'(count_r - 1'b1);
      end
    end
  end

  for (genvar i = 0; i < ile_pkg::CAPACITY; i++) begin : g_cell
    logic [ile_pkg::DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == ile_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    ile_cell u_cell (
      .clk       (clk),
      .cmd_i     (cmd),
      .cell_id_i (ile_pkg::IDX_W'(i)),
      .left_i    (left_w),
      .right_i   (right_w),
      .data_o    (cell_data[i]),
      .rd_o      (cell_rd[i])
    );
  end

  // Only the addressed cell drives a nonzero word
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < ile_pkg::CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_value_r <= read_value_nxt;
      out_ok_r         <= ok_nxt;
      out_length_r     <= ile_pkg::LEN_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_ok         = out_ok_r;
  assign out_length     = out_length_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ile_pkg::CNT_W'(ile_pkg::CAPACITY))
    else $error("list length above capacity");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !accept) |=> $stable(count_r))
    else $error("length changed without a transaction");

  a_refused_count: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && accept && !ok_nxt) |=> $stable(count_r))
    else $error("refused request changed length");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && accept) |=> (count_r == $past(count_r) ||
      count_r == ile_pkg::CNT_W'($past(count_r) + 1'b1) ||
      count_r == ile_pkg::CNT_W'($past(count_r) - 1'b1)))
    else $error("length moved by more than one");

  a_len_match: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && accept) |=> (out_length_r == ile_pkg::LEN_W'(count_r)))
    else $error("reported length differs from stored length");

endmodule
